// File: rtl/b64dec_pkg.sv
// Package for the base64 stream decoder: types, constants and helper functions.
package b64dec_pkg;

  // Result buffer depth and derived widths
  localparam int FifoDepth = 8;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CntW      = $clog2(FifoDepth + 1);
  // Most results one character can release
  localparam int MaxRes    = 3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       decode_error;
    logic       end_of_message;
  } out_req_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } char_val_t;

  typedef struct packed {
    logic [1:0] nb;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       err;
  } flush_t;

  localparam logic ALPHA_STD = 1'b0;
  localparam logic ALPHA_URL = 1'b1;

  // Six-bit value of a character in the selected alphabet
  function automatic char_val_t char_value(input logic [7:0] c, input logic url);
    char_val_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      r.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.val = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.val = 6'(c - 8'h30 + 8'd52);
    end else if (url == ALPHA_URL && c == 8'h2D) begin
      r.val = 6'd62;
    end else if (url == ALPHA_URL && c == 8'h5F) begin
      r.val = 6'd63;
    end else if (url == ALPHA_STD && c == 8'h2B) begin
      r.val = 6'd62;
    end else if (url == ALPHA_STD && c == 8'h2F) begin
      r.val = 6'd63;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // Bytes held by a partial group; a single character is an error
  function automatic flush_t flush_partial(input logic [17:0] bits, input logic [1:0] cnt);
    flush_t f;
    f = '0;
    case (cnt)
      2'd1: f.err = 1'b1;
      2'd2: begin
        f.nb = 2'd1;
        f.b0 = bits[11:4];
      end
      2'd3: begin
        f.nb = 2'd2;
        f.b0 = bits[17:10];
        f.b1 = bits[9:2];
      end
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/base64_stream_decoder_top.sv
// Top level of the base64 stream decoder: character decode and result buffer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_stall  | in_data  (char, last flag)
//  out     | output    | out_valid / out_stall| out_data (byte, flags)
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (alphabet select)
//
// One character is decoded per cycle as it is accepted; its zero to three results go
// into an 8-entry result buffer that drains one request per cycle while out_stall is low.
// in_stall rises while the buffer has fewer than three free entries, so a long stall
// on the output side backs up to the input after a few characters.
// Synchronous reset clears the decode state, the buffer and the alphabet register.
module base64_stream_decoder_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64dec_pkg::in_req_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64dec_pkg::out_req_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  localparam int Depth = b64dec_pkg::FifoDepth;
  localparam int PtrW  = b64dec_pkg::PtrW;
  localparam int CntW  = b64dec_pkg::CntW;
  localparam int MaxR  = b64dec_pkg::MaxRes;

  logic                 alpha;
  logic [17:0]          group_bits, group_bits_next;
  logic [1:0]           group_count, group_count_next;
  logic                 stopped, stopped_next;
  logic                 error_seen, error_seen_next;

  b64dec_pkg::out_req_t fifo [Depth];
  logic [PtrW-1:0]      wr_ptr, rd_ptr;
  logic [CntW-1:0]      count;

  b64dec_pkg::out_req_t res [MaxR];
  logic [1:0]           nres;
  logic                 in_acc, out_acc;

  b64dec_pkg::char_val_t cv;
  b64dec_pkg::flush_t    fl;

  assign in_stall  = count > CntW'(Depth - MaxR);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = count != '0;
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = fifo[rd_ptr];

  always_comb begin
    logic [1:0] nb;
    logic [7:0] b [MaxR];
    nb               = '0;
    for (int i = 0; i < MaxR; i++) b[i] = '0;
    group_bits_next  = group_bits;
    group_count_next = group_count;
    stopped_next     = stopped;
    error_seen_next  = error_seen;
    cv = b64dec_pkg::char_value(in_data.in_char, alpha);
    fl = '0;

    if (!stopped) begin
      if (!cv.ok) begin
        stopped_next = 1'b1;
        fl = b64dec_pkg::flush_partial(group_bits, group_count);
        group_bits_next  = '0;
        group_count_next = '0;
      end else if (group_count == 2'd3) begin
        nb   = 2'd3;
        b[0] = group_bits[17:10];
        b[1] = group_bits[9:2];
        b[2] = {group_bits[1:0], cv.val};
        group_bits_next  = '0;
        group_count_next = '0;
      end else begin
        group_bits_next  = {group_bits[11:0], cv.val};
        group_count_next = group_count + 2'd1;
      end
    end

    // message ends without an end character: flush what is pending
    if (in_data.last_char && !stopped_next) begin
      fl = b64dec_pkg::flush_partial(group_bits_next, group_count_next);
    end

    if (fl.nb != '0 || fl.err) begin
      nb   = fl.nb;
      b[0] = fl.b0;
      b[1] = fl.b1;
      if (fl.err) error_seen_next = 1'b1;
    end

    for (int i = 0; i < MaxR; i++) begin
      res[i].out_byte       = b[i];
      res[i].byte_valid     = 2'(i) < nb;
      res[i].decode_error   = 1'b0;
      res[i].end_of_message = 1'b0;
    end
    nres = nb;

    if (in_data.last_char) begin
      if (nb == '0) nres = 2'd1;
      res[nres - 2'd1].decode_error   = error_seen_next;
      res[nres - 2'd1].end_of_message = 1'b1;
      group_bits_next  = '0;
      group_count_next = '0;
      stopped_next     = 1'b0;
      error_seen_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha       <= b64dec_pkg::ALPHA_STD;
      group_bits  <= '0;
      group_count <= '0;
      stopped     <= 1'b0;
      error_seen  <= 1'b0;
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
    end else begin
      if (cfg_wr_en) alpha <= cfg_wr_data;
      if (in_acc) begin
        group_bits  <= group_bits_next;
        group_count <= group_count_next;
        stopped     <= stopped_next;
        error_seen  <= error_seen_next;
        wr_ptr      <= wr_ptr + PtrW'(nres);
      end
      if (out_acc) rd_ptr <= rd_ptr + PtrW'(1);
      count <= count + (in_acc ? CntW'(nres) : CntW'(0)) - (out_acc ? CntW'(1) : CntW'(0));
    end
  end

  // result buffer entries
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MaxR; i++) begin
        if (2'(i) < nres) fifo[wr_ptr + PtrW'(i)] <= res[i];
      end
    end
  end

endmodule

// File: rtl/b64dec_checker.sv
// Port-level checker for the base64 stream decoder, bound to the top level.
module b64dec_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input b64dec_pkg::out_req_t out_data
);

  // buffer is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("outputs not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output request changed");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.end_of_message)
    else $error("request without byte is not an end marker");

  a_err_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.decode_error |-> out_data.end_of_message)
    else $error("error flag outside end of message");

endmodule

bind base64_stream_decoder_top b64dec_checker u_b64dec_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
